// File: hdl/ris_pkg.sv
// Shared types and constants for the rational integer scaler.
// Depends on nothing; imported by the top level, its arithmetic units and the bench.

package ris_pkg;

    localparam int FIELD_W = 32;
    localparam int MODE_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_INT  = 3'd0,
        MODE_LOAD_FRAC = 3'd1,
        MODE_SET_ONE   = 3'd2,
        MODE_MULTIPLY  = 3'd3,
        MODE_DIVIDE    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;

    // Start request to, and completion from, one of the serial units.
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic done;
    } t_unit_rsp;

endpackage

// File: hdl/ris_gcd.sv
// Binary greatest common divisor unit, one shift or subtract-and-shift a cycle.
// Depends on ris_pkg for the unit request and response types.

module ris_gcd
    import ris_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_unit_req              i_req,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    output t_unit_rsp              o_rsp,
    output logic [VALUE_WIDTH-1:0] o_g,
    output logic [VALUE_WIDTH-1:0] o_dvd_a,
    output logic [VALUE_WIDTH-1:0] o_dvd_b
);

    localparam int W = VALUE_WIDTH;

    logic         r_busy;
    logic         r_done;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic [W-1:0] r_da;
    logic [W-1:0] r_db;
    logic [W:0]   w_diff_ab;
    logic [W:0]   w_diff_ba;

    assign w_diff_ab = {1'b0, r_a} - {1'b0, r_b};
    assign w_diff_ba = {1'b0, r_b} - {1'b0, r_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_a == '0 || r_b == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The dividends follow every common halving, so that dividing them by the
    // odd part of the divisor gives the same exact quotients.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_da <= i_a;
            r_db <= i_b;
        end else if (r_busy && r_a != '0 && r_b != '0) begin
            case ({r_a[0], r_b[0]})
                2'b00: begin
                    r_a  <= r_a >> 1;
                    r_b  <= r_b >> 1;
                    r_da <= r_da >> 1;
                    r_db <= r_db >> 1;
                end
                2'b01: r_a <= r_a >> 1;
                2'b10: r_b <= r_b >> 1;
                default: begin
                    if (!w_diff_ab[W]) begin
                        r_a <= {1'b0, w_diff_ab[W-1:1]};
                    end else begin
                        r_b <= {1'b0, w_diff_ba[W-1:1]};
                    end
                end
            endcase
        end
    end

    // When the loop ends one of the pair is zero.
    assign o_g      = r_a | r_b;
    assign o_dvd_a  = r_da;
    assign o_dvd_b  = r_db;
    assign o_rsp.done = r_done;

endmodule

// File: hdl/ris_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit a cycle.
// Depends on ris_pkg for the unit request and response types.

module ris_div
    import ris_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_unit_req              i_req,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    input  logic [VALUE_WIDTH-1:0] i_dvd_a,
    input  logic [VALUE_WIDTH-1:0] i_dvd_b,
    output t_unit_rsp              o_rsp,
    output logic [VALUE_WIDTH-1:0] o_quo_a,
    output logic [VALUE_WIDTH-1:0] o_quo_b
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_div;
    logic [W-1:0]  r_rem_a;
    logic [W-1:0]  r_rem_b;
    logic [W-1:0]  r_q_a;
    logic [W-1:0]  r_q_b;
    logic [W:0]    w_trial_a;
    logic [W:0]    w_trial_b;
    logic [W:0]    w_sub_a;
    logic [W:0]    w_sub_b;
    logic          w_ge_a;
    logic          w_ge_b;
    logic [W-1:0]  n_rem_a;
    logic [W-1:0]  n_rem_b;

    always_comb begin
        w_trial_a = {r_rem_a, r_q_a[W-1]};
        w_trial_b = {r_rem_b, r_q_b[W-1]};
        w_sub_a   = w_trial_a - {1'b0, r_div};
        w_sub_b   = w_trial_b - {1'b0, r_div};
        w_ge_a    = !w_sub_a[W];
        w_ge_b    = !w_sub_b[W];
        n_rem_a   = w_ge_a ? w_sub_a[W-1:0] : w_trial_a[W-1:0];
        n_rem_b   = w_ge_b ? w_sub_b[W-1:0] : w_trial_b[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div   <= i_divisor;
            r_rem_a <= '0;
            r_rem_b <= '0;
            r_q_a   <= i_dvd_a;
            r_q_b   <= i_dvd_b;
        end else if (r_busy) begin
            r_rem_a <= n_rem_a;
            r_rem_b <= n_rem_b;
            r_q_a   <= {r_q_a[W-2:0], w_ge_a};
            r_q_b   <= {r_q_b[W-2:0], w_ge_b};
        end
    end

    assign o_quo_a    = r_q_a;
    assign o_quo_b    = r_q_b;
    assign o_rsp.done = r_done;

endmodule

// File: hdl/ris_mul.sv
// Shift-and-add magnitude multiplier, one multiplier bit a cycle, with a
// signed wrap result and overflow check. Depends on ris_pkg for unit types.

module ris_mul
    import ris_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_unit_req              i_req,
    input  logic [VALUE_WIDTH-1:0] i_mcand,
    input  logic [VALUE_WIDTH-1:0] i_mplier,
    input  logic                   i_neg,
    output t_unit_rsp              o_rsp,
    output logic [VALUE_WIDTH-1:0] o_prod,
    output logic                   o_ovf
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [W-1:0]   r_mcand;
    logic           r_neg;
    logic [2*W-1:0] r_acc;
    logic [W:0]     w_sum;
    logic           w_hi_nz;

    assign w_sum = {1'b0, r_acc[2*W-1:W]} + (r_acc[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_mcand;
            r_neg   <= i_neg;
            r_acc   <= {{W{1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[W-1:1]};
        end
    end

    // A negative result may reach one more than the largest positive value.
    assign w_hi_nz = |r_acc[2*W-1:W];
    assign o_prod  = r_neg ? (-r_acc[W-1:0]) : r_acc[W-1:0];
    assign o_ovf   = r_neg ? (w_hi_nz || (r_acc[W-1] && (|r_acc[W-2:0])))
                           : (w_hi_nz || r_acc[W-1]);
    assign o_rsp.done = r_done;

endmodule

// File: hdl/rational_integer_scaler_unit.sv
// Rational integer scaler: holds a signed numerator and denominator and, per
// input word, loads a value or scales it by an integer after reducing by a gcd.
// A load, a set to one or a refused word passes from acceptance through the execute
// and output states to the output register. A multiply or divide runs three serial
// units in turn: the binary gcd loop (whose run shortens for small operands), the
// exact two-lane divider and the shift-and-add multiplier. One word is worked on
// at a time; the next is accepted while the previous result word waits in the
// output register. Depends on ris_pkg, ris_gcd, ris_div and ris_mul.

module rational_integer_scaler_unit
    import ris_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [FIELD_W-1:0] i_operand_value,
    input  logic signed [FIELD_W-1:0] i_operand_denominator,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [FIELD_W-1:0] o_numerator_out,
    output logic signed [FIELD_W-1:0] o_denominator_out,
    output logic                      o_overflow,
    output logic                      o_error
);

    localparam int W = VALUE_WIDTH;

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [W-1:0]       r_opnd, n_opnd;
    logic [W-1:0]       r_opden, n_opden;
    logic [W-1:0]       r_num, n_num;
    logic [W-1:0]       r_den, n_den;
    logic               r_ovf, n_ovf;
    logic               r_err, n_err;
    logic               r_out_valid, n_out_valid;
    logic [FIELD_W-1:0] r_out_num, n_out_num;
    logic [FIELD_W-1:0] r_out_den, n_out_den;
    logic               r_out_ovf, n_out_ovf;
    logic               r_out_err, n_out_err;

    logic [W-1:0]       w_in_val;
    logic [W-1:0]       w_in_den;
    logic [FIELD_W-1:0] w_num_fld;
    logic [FIELD_W-1:0] w_den_fld;
    logic [W-1:0]       w_t;
    logic [W-1:0]       w_other;
    logic [W-1:0]       w_s_mag;
    logic [W-1:0]       w_t_mag;
    logic [W-1:0]       w_other_mag;
    logic [W-1:0]       w_t_quo_signed;

    t_unit_req          w_gcd_req, w_div_req, w_mul_req;
    t_unit_rsp          w_gcd_rsp, w_div_rsp, w_mul_rsp;
    logic [W-1:0]       w_gcd_g;
    logic [W-1:0]       w_gcd_da;
    logic [W-1:0]       w_gcd_db;
    logic [W-1:0]       w_quo_s;
    logic [W-1:0]       w_quo_t;
    logic [W-1:0]       w_mul_prod;
    logic               w_mul_ovf;

    // Fit the 32-bit fields to the held width and back.
    if (W <= FIELD_W) begin : g_in_fit
        assign w_in_val = i_operand_value[W-1:0];
        assign w_in_den = i_operand_denominator[W-1:0];
    end else begin : g_in_ext
        assign w_in_val = {{(W-FIELD_W){i_operand_value[FIELD_W-1]}}, i_operand_value};
        assign w_in_den = {{(W-FIELD_W){i_operand_denominator[FIELD_W-1]}},
                           i_operand_denominator};
    end

    if (W >= FIELD_W) begin : g_out_fit
        assign w_num_fld = r_num[FIELD_W-1:0];
        assign w_den_fld = r_den[FIELD_W-1:0];
    end else begin : g_out_ext
        assign w_num_fld = {{(FIELD_W-W){r_num[W-1]}}, r_num};
        assign w_den_fld = {{(FIELD_W-W){r_den[W-1]}}, r_den};
    end

    // A multiply reduces against the denominator, a divide against the numerator.
    always_comb begin
        w_t            = (r_mode == MODE_MULTIPLY) ? r_den : r_num;
        w_other        = (r_mode == MODE_MULTIPLY) ? r_num : r_den;
        w_s_mag        = r_opnd[W-1] ? (-r_opnd) : r_opnd;
        w_t_mag        = w_t[W-1] ? (-w_t) : w_t;
        w_other_mag    = w_other[W-1] ? (-w_other) : w_other;
        w_t_quo_signed = w_t[W-1] ? (-w_quo_t) : w_quo_t;
    end

    ris_gcd #(
        .VALUE_WIDTH (W)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_gcd_req),
        .i_a     (w_s_mag),
        .i_b     (w_t_mag),
        .o_rsp   (w_gcd_rsp),
        .o_g     (w_gcd_g),
        .o_dvd_a (w_gcd_da),
        .o_dvd_b (w_gcd_db)
    );

    ris_div #(
        .VALUE_WIDTH (W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_divisor (w_gcd_g),
        .i_dvd_a   (w_gcd_da),
        .i_dvd_b   (w_gcd_db),
        .o_rsp     (w_div_rsp),
        .o_quo_a   (w_quo_s),
        .o_quo_b   (w_quo_t)
    );

    ris_mul #(
        .VALUE_WIDTH (W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mul_req),
        .i_mcand  (w_other_mag),
        .i_mplier (w_quo_s),
        .i_neg    (w_other[W-1] ^ r_opnd[W-1]),
        .o_rsp    (w_mul_rsp),
        .o_prod   (w_mul_prod),
        .o_ovf    (w_mul_ovf)
    );

    always_comb begin
        n_state         = r_state;
        n_mode          = r_mode;
        n_opnd          = r_opnd;
        n_opden         = r_opden;
        n_num           = r_num;
        n_den           = r_den;
        n_ovf           = r_ovf;
        n_err           = r_err;
        n_out_valid     = r_out_valid;
        n_out_num       = r_out_num;
        n_out_den       = r_out_den;
        n_out_ovf       = r_out_ovf;
        n_out_err       = r_out_err;
        w_gcd_req.start = 1'b0;
        w_div_req.start = 1'b0;
        w_mul_req.start = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = t_mode'(i_mode);
                    n_opnd  = w_in_val;
                    n_opden = w_in_den;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_ovf   = 1'b0;
                n_err   = 1'b0;
                n_state = ST_OUT;
                unique case (r_mode) inside
                    MODE_LOAD_INT: begin
                        n_num = r_opnd;
                        n_den = W'(1);
                    end
                    MODE_LOAD_FRAC: begin
                        n_num = r_opnd;
                        n_den = r_opden;
                    end
                    MODE_SET_ONE: begin
                        n_num = W'(1);
                        n_den = W'(1);
                    end
                    MODE_MULTIPLY, MODE_DIVIDE: begin
                        // Both operands zero leaves no divisor: refuse the word.
                        if (w_s_mag == '0 && w_t_mag == '0) begin
                            n_err = 1'b1;
                        end else begin
                            w_gcd_req.start = 1'b1;
                            n_state         = ST_GCD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_GCD: begin
                if (w_gcd_rsp.done) begin
                    w_div_req.start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    if (r_mode == MODE_MULTIPLY) begin
                        n_den = w_t_quo_signed;
                    end else begin
                        n_num = w_t_quo_signed;
                    end
                    w_mul_req.start = 1'b1;
                    n_state         = ST_MUL;
                end
            end
            ST_MUL: begin
                if (w_mul_rsp.done) begin
                    if (r_mode == MODE_MULTIPLY) begin
                        n_num = w_mul_prod;
                    end else begin
                        n_den = w_mul_prod;
                    end
                    n_ovf   = w_mul_ovf;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_num   = w_num_fld;
                    n_out_den   = w_den_fld;
                    n_out_ovf   = r_ovf;
                    n_out_err   = r_err;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num       <= '0;
            r_den       <= W'(1);
            r_ovf       <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num       <= n_num;
            r_den       <= n_den;
            r_ovf       <= n_ovf;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_opnd    <= n_opnd;
        r_opden   <= n_opden;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
        r_out_ovf <= n_out_ovf;
        r_out_err <= n_out_err;
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_numerator_out   = r_out_num;
    assign o_denominator_out = r_out_den;
    assign o_overflow        = r_out_ovf;
    assign o_error           = r_out_err;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_EXEC))
        else $error("accepted word did not enter execution");

    a_gcd_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gcd_rsp.done |-> (r_state == ST_GCD && w_gcd_g != '0))
        else $error("gcd completion outside its phase or with a zero divisor");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider completion outside its phase");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == ST_MUL))
        else $error("multiplier completion outside its phase");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_ovf && r_out_err))
        else $error("a refused word also reports a wrapped product");

endmodule

// File: bench/ris_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the rational integer scaler: watches both word channels,
// keeps its own copy of the held fraction and compares every result word.
// Depends on ris_pkg for the mode codes and field widths.

module ris_result_checker
    import ris_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [FIELD_W-1:0] i_operand_value,
    input  logic signed [FIELD_W-1:0] i_operand_denominator,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [FIELD_W-1:0] i_numerator,
    input  logic signed [FIELD_W-1:0] i_denominator,
    input  logic                      i_overflow,
    input  logic                      i_error,
    output int                        o_fail_count,
    output int                        o_outstanding
);

    typedef logic signed [FIELD_W-1:0] t_value;

    typedef struct {
        t_value num;
        t_value den;
        logic   ovf;
        logic   err;
    } t_fraction_word;

    t_fraction_word expected_fractions[$];
    t_value         model_num = '0;
    t_value         model_den = 1;
    int             mismatch_count = 0;
    int             waiting_words = 0;

    assign o_fail_count  = mismatch_count;
    assign o_outstanding = waiting_words;

    function automatic longint unsigned magnitude(t_value v);
        longint s;
        s = v;
        return (s < 0) ? -s : s;
    endfunction

    function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // The gcd always divides the value, so the quotient is exact and keeps the sign.
    function automatic t_value exact_quotient(t_value v, longint unsigned g);
        longint q;
        q = magnitude(v) / g;
        if (v < 0) begin
            q = -q;
        end
        return q[FIELD_W-1:0];
    endfunction

    function automatic t_value wrapped_product(t_value a, t_value b, output logic wrapped);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned limit;
        longint          p;
        ma = magnitude(a);
        mb = magnitude(b);
        limit = ((a < 0) != (b < 0)) ? 64'h8000_0000 : 64'h7FFF_FFFF;
        wrapped = (ma != 0) && (mb > limit / ma);
        p = longint'(a) * longint'(b);
        return p[FIELD_W-1:0];
    endfunction

    // Applies one input word to the model fraction and returns the word it should produce.
    function automatic t_fraction_word predict_scaling(logic [MODE_W-1:0] mode, t_value v,
                                                       t_value d);
        t_fraction_word  w;
        longint unsigned g;
        logic            wrapped;
        wrapped = 1'b0;
        w.err = 1'b0;
        case (mode)
            MODE_LOAD_INT: begin
                model_num = v;
                model_den = 1;
            end
            MODE_LOAD_FRAC: begin
                model_num = v;
                model_den = d;
            end
            MODE_SET_ONE: begin
                model_num = 1;
                model_den = 1;
            end
            MODE_MULTIPLY: begin
                g = euclid_gcd(magnitude(v), magnitude(model_den));
                if (g == 0) begin
                    w.err = 1'b1;
                end else begin
                    model_den = exact_quotient(model_den, g);
                    model_num = wrapped_product(model_num, exact_quotient(v, g), wrapped);
                end
            end
            MODE_DIVIDE: begin
                g = euclid_gcd(magnitude(v), magnitude(model_num));
                if (g == 0) begin
                    w.err = 1'b1;
                end else begin
                    model_num = exact_quotient(model_num, g);
                    model_den = wrapped_product(model_den, exact_quotient(v, g), wrapped);
                end
            end
            default: begin
            end
        endcase
        w.num = model_num;
        w.den = model_den;
        w.ovf = wrapped;
        return w;
    endfunction

    task automatic note_failure(string text);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s", $realtime, text);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_fraction_word want;
        if (!i_rst_n) begin
            model_num = '0;
            model_den = 1;
            expected_fractions.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_fractions.push_back(predict_scaling(i_mode, i_operand_value,
                                                             i_operand_denominator));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_fractions.size() == 0) begin
                    note_failure($sformatf("result word with nothing expected: num=%0d den=%0d",
                                           i_numerator, i_denominator));
                end else begin
                    want = expected_fractions.pop_front();
                    if (i_numerator !== want.num || i_denominator !== want.den ||
                        i_overflow !== want.ovf || i_error !== want.err) begin
                        note_failure($sformatf(
                            {"mismatch: expected num=%0d den=%0d ovf=%b err=%b, ",
                             "got num=%0d den=%0d ovf=%b err=%b"},
                            want.num, want.den, want.ovf, want.err,
                            i_numerator, i_denominator, i_overflow, i_error));
                    end
                end
            end
        end
        waiting_words = expected_fractions.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the rational integer scaler bench: clock, reset, stimulus and the verdict.
// Depends on ris_pkg, rational_integer_scaler_unit and ris_result_checker.

module tb_top;
    import ris_pkg::*;

    localparam int TOTAL_ITEMS  = 550;
    localparam int HOLD_CYCLES  = 500;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [MODE_W-1:0]         i_mode;
    logic signed [FIELD_W-1:0] i_operand_value;
    logic signed [FIELD_W-1:0] i_operand_denominator;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [FIELD_W-1:0] o_numerator_out;
    logic signed [FIELD_W-1:0] o_denominator_out;
    logic                      o_overflow;
    logic                      o_error;

    int fail_count;
    int outstanding;
    int hold_requests = 0;
    int holds_served  = 0;
    int scaled_items  = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b1;
    bit offering      = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rational_integer_scaler_unit uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_mode                (i_mode),
        .i_operand_value       (i_operand_value),
        .i_operand_denominator (i_operand_denominator),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_numerator_out       (o_numerator_out),
        .o_denominator_out     (o_denominator_out),
        .o_overflow            (o_overflow),
        .o_error               (o_error)
    );

    ris_result_checker u_results (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .i_in_ready            (o_in_ready),
        .i_mode                (i_mode),
        .i_operand_value       (i_operand_value),
        .i_operand_denominator (i_operand_denominator),
        .i_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .i_numerator           (o_numerator_out),
        .i_denominator         (o_denominator_out),
        .i_overflow            (o_overflow),
        .i_error               (o_error),
        .o_fail_count          (fail_count),
        .o_outstanding         (outstanding)
    );

    // Mostly small operands so that sequences of scalings stay meaningful.
    function automatic logic signed [FIELD_W-1:0] pick_operand();
        logic signed [FIELD_W-1:0] m;
        case ($urandom_range(0, 9))
            0: m = '0;
            6: m = $urandom;
            7: m = 32'sd1 <<< $urandom_range(0, 30);
            8: begin
                case ($urandom_range(0, 3))
                    0: m = VAL_MIN;
                    1: m = VAL_MAX;
                    2: m = -1;
                    default: m = 1;
                endcase
            end
            9: m = $urandom_range(1, 100000);
            default: m = $urandom_range(1, 60);
        endcase
        if (m != VAL_MIN && $urandom_range(0, 1) == 1) begin
            m = -m;
        end
        return m;
    endfunction

    task automatic offer(logic [MODE_W-1:0] mode, logic signed [FIELD_W-1:0] val,
                         logic signed [FIELD_W-1:0] den);
        bit drain_now;
        drain_now = 1'b0;
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_operand_value <= val;
        i_operand_denominator <= den;
        offering = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (mode <= MODE_DIVIDE) begin
            scaled_items++;
            case (scaled_items)
                150, 380: hold_requests <= hold_requests + 1;
                200: gaps_on = 1'b0;
                300: gaps_on = 1'b1;
                260, 470: drain_now = 1'b1;
                default: begin
                end
            endcase
        end
        if (drain_now) begin
            // Let every outstanding word come back before offering more.
            i_in_valid <= 1'b0;
            offering = 1'b0;
            do @(negedge i_clk); while (outstanding != 0);
            @(posedge i_clk);
        end else if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_on) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8))
                @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    initial begin : stimulus
        int seq_len;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_mode <= MODE_SET_ONE;
        i_operand_value <= '0;
        i_operand_denominator <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(MODE_LOAD_INT, 0, 7);
        offer(MODE_MULTIPLY, 0, 0);
        offer(MODE_DIVIDE, 0, 0);              // zero by zero is refused
        offer(MODE_LOAD_INT, VAL_MAX, VAL_MIN);
        offer(MODE_MULTIPLY, 2, 0);            // wraps
        offer(MODE_LOAD_INT, VAL_MIN, -1);
        offer(MODE_MULTIPLY, -1, 0);
        offer(MODE_DIVIDE, -1, 0);
        offer(MODE_LOAD_FRAC, 3, 0);           // zero denominator is stored as given
        offer(MODE_MULTIPLY, 0, 0);
        offer(MODE_MULTIPLY, 6, 0);
        offer(MODE_LOAD_FRAC, -12, -18);
        offer(MODE_MULTIPLY, 9, 0);
        offer(MODE_DIVIDE, -8, 0);
        offer(MODE_SET_ONE, VAL_MIN, VAL_MAX);
        offer(MODE_DIVIDE, VAL_MAX, 0);
        offer(MODE_DIVIDE, 3, 0);
        offer(MODE_LOAD_FRAC, VAL_MAX, VAL_MIN);
        offer(MODE_MULTIPLY, VAL_MIN, 0);
        offer(3'd5, $urandom, $urandom);
        offer(3'd6, $urandom, $urandom);
        offer(3'd7, VAL_MIN, VAL_MAX);
        offer(MODE_LOAD_FRAC, 0, 0);
        offer(MODE_DIVIDE, 0, 0);
        offer(MODE_DIVIDE, 5, -1);

        while (scaled_items < TOTAL_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                offer(MODE_W'($urandom_range(0, 7)), $urandom, $urandom);
            end else begin
                case ($urandom_range(0, 2))
                    0: offer(MODE_LOAD_INT, pick_operand(), $urandom);
                    1: offer(MODE_LOAD_FRAC, pick_operand(), pick_operand());
                    default: offer(MODE_SET_ONE, $urandom, $urandom);
                endcase
                seq_len = $urandom_range(2, 8);
                repeat (seq_len) begin
                    offer(($urandom_range(0, 1) == 1) ? MODE_MULTIPLY : MODE_DIVIDE,
                          pick_operand(), $urandom);
                end
            end
        end

        if (offering) begin
            i_in_valid <= 1'b0;
        end
        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // The receiver changes its stall style every so often and takes long holds on request.
    initial begin : receiver
        int style;
        int cycle;
        style = 0;
        cycle = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle % 256 == 0) begin
                style = $urandom_range(0, 3);
            end
            if (hold_requests > holds_served) begin
                holds_served++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                case (style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    2: i_out_ready <= ($urandom_range(0, 7) == 0);
                    default: i_out_ready <= ((cycle % 5) < 3);
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule
